[hw/rtl/five_point_stencil_sweep_defines.svh]
// ============================================================================
// Assertion macros for the five-point stencil sweep
// Shared property shorthands on i_clk; all but the last qualified by i_rst_n.
// ============================================================================
`ifndef FIVE_POINT_STENCIL_SWEEP_DEFINES_SVH
`define FIVE_POINT_STENCIL_SWEEP_DEFINES_SVH

// Same-cycle implication, ignored while reset is held
`define FPSS_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is held
`define FPSS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset
`define FPSS_ASSERT_NEXT_ALWAYS(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/fpss_pkg.sv]
// ============================================================================
// fpss_pkg
// Shared constants and types of the five-point stencil sweep.
// ============================================================================
package fpss_pkg;

    localparam int unsigned MAX_DIM_DEF = 1024;
    localparam int unsigned MIN_DIM     = 3;
    localparam int unsigned GRID_W      = 11;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned IDX_W       = 10;
    localparam int unsigned Q_DEPTH     = 4;
    localparam int unsigned OUT_TDATA_W = 56;

    // stencil sum, magnitude split and product widths
    localparam int unsigned PAIR_W = DATA_W + 1;
    localparam int unsigned SUM_W  = DATA_W + 3;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned HI_W   = SUM_W - FRAC_W;
    localparam int unsigned PHI_W  = HI_W + DATA_W;
    localparam int unsigned PLO_W  = FRAC_W + DATA_W;
    localparam int unsigned Q_W    = PHI_W + 1;

    localparam logic [GRID_W-1:0] GRID_RST  = 11'd1024;
    localparam logic [DATA_W-1:0] SCALE_RST = 32'd16384;
    localparam logic [DATA_W-1:0] SAT_POS   = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_NEG   = 32'h8000_0000;

    typedef enum logic [0:0] {
        REG_GRID_SIZE    = 1'b0,
        REG_SCALE_FACTOR = 1'b1
    } t_reg_idx;

    // what the front works out for each item
    typedef struct packed {
        logic [IDX_W-1:0] out_col;
        logic [IDX_W-1:0] out_row;
        logic             interior;
        logic             last;
    } t_tag;

    // one line-store entry: rows r-2 and r-1 of a column
    typedef struct packed {
        logic [DATA_W-1:0] above;
        logic [DATA_W-1:0] middle;
    } t_line;

endpackage

[hw/rtl/five_point_stencil_sweep.sv]
// ============================================================================
// five_point_stencil_sweep
// Five-point Laplacian over a square grid streamed in raster order.
// ============================================================================
// Usage:
//   s_axis carries one grid sample per item: tdata = sample (Q16.16),
//   tuser = grid_start, which puts the sample at row 0, column 0. After the
//   last point of a grid the position wraps, so grids may follow directly.
//   m_axis gives one item per interior point: scale * (up + down + left +
//   right - 4*centre), truncated toward zero and saturated, with the point's
//   row and column; tlast marks the last interior point of a grid.
//   Boundary points produce nothing.
//   Config: i_cfg_we writes register i_cfg_idx (grid size, scale factor)
//   from i_cfg_wdata; write only while the block is idle.
// Timing: one item per cycle sustained while m_axis_tready is high. Each
//   sample goes through the line-store read as it leaves the queue, then
//   six stages of pair add, sum, magnitude, split multiply, product sum and
//   saturate.
// Reset: position to (0,0), registers to grid 1024 and scale 0.25, queue
//   and pipeline emptied. Line stores are not cleared; only rows written in
//   the current grid are read.
// Stall: while a result waits on a low m_axis_tready the back pipeline halts
//   as a whole; the four-entry queue keeps taking items, and s_axis_tready
//   drops when full.
// ============================================================================
module five_point_stencil_sweep #(
    parameter int unsigned MAX_DIM = fpss_pkg::MAX_DIM_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  fpss_pkg::t_reg_idx                 i_cfg_idx,
    input  logic [fpss_pkg::DATA_W-1:0]        i_cfg_wdata,
    // sample input
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [fpss_pkg::DATA_W-1:0]        s_axis_tdata,  // [31:0] sample
    input  logic                               s_axis_tuser,  // [0] grid_start
    // result output
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [fpss_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // [31:0] result,
                                                              // [41:32] out_row,
                                                              // [51:42] out_col,
                                                              // [55:52] zero
    output logic                               m_axis_tlast   // last_point
);
    import fpss_pkg::*;

    localparam int unsigned CW    = $clog2(MAX_DIM);
    localparam int unsigned NW    = $clog2(MAX_DIM+1);
    localparam int unsigned CMPW  = (NW > GRID_W) ? NW : GRID_W;
    localparam int unsigned ITEMW = DATA_W + CW + $bits(t_tag);

    localparam logic [CMPW-1:0] MAX_C   = CMPW'(MAX_DIM);
    localparam logic [CMPW-1:0] MIN_C   = CMPW'(MIN_DIM);
    localparam logic [CMPW-1:0] GRST_C  = CMPW'(GRID_RST);
    localparam logic [NW-1:0]   EFF_RST = (GRST_C > MAX_C) ? MAX_C[NW-1:0] : GRST_C[NW-1:0];

    // effective grid size and factor magnitude kept ready-made
    logic [NW-1:0]     r_eff_size;
    logic [DATA_W-1:0] r_fac_mag;
    logic              r_fac_neg;

    logic [CMPW-1:0]   wr_gs;
    logic [NW-1:0]     wr_eff;
    logic [DATA_W-1:0] wr_mag;

    logic              accept, q_full, q_empty, q_pop;
    logic [CW-1:0]     front_col;
    t_tag              front_tag;
    logic [ITEMW-1:0]  q_in, q_out;

    logic [DATA_W-1:0] res;
    logic [IDX_W-1:0]  res_row, res_col;
    logic              res_last;

    // grid size clamped to 3 .. MAX_DIM at write time
    assign wr_gs = CMPW'(i_cfg_wdata[GRID_W-1:0]);
    always_comb begin
        if (wr_gs < MIN_C) begin
            wr_eff = MIN_C[NW-1:0];
        end else if (wr_gs > MAX_C) begin
            wr_eff = MAX_C[NW-1:0];
        end else begin
            wr_eff = wr_gs[NW-1:0];
        end
    end
    assign wr_mag = i_cfg_wdata[DATA_W-1] ? (~i_cfg_wdata + 1'b1) : i_cfg_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_size <= EFF_RST;
            r_fac_mag  <= SCALE_RST;
            r_fac_neg  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GRID_SIZE: begin
                    r_eff_size <= wr_eff;
                end
                REG_SCALE_FACTOR: begin
                    r_fac_mag <= wr_mag;
                    r_fac_neg <= i_cfg_wdata[DATA_W-1];
                end
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = ~q_full;
    assign accept        = s_axis_tvalid & ~q_full;

    fpss_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_eff_size   (r_eff_size),
        .i_accept     (accept),
        .i_grid_start (s_axis_tuser),
        .o_col        (front_col),
        .o_tag        (front_tag)
    );

    assign q_in = {front_tag, front_col, s_axis_tdata};

    fpss_queue #(
        .W (ITEMW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_pop   (q_pop),
        .i_data  (q_in),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    fpss_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (~q_empty),
        .i_sample  (q_out[DATA_W-1:0]),
        .i_col     (q_out[DATA_W+CW-1:DATA_W]),
        .i_tag     (q_out[ITEMW-1:DATA_W+CW]),
        .i_fac_mag (r_fac_mag),
        .i_fac_neg (r_fac_neg),
        .i_m_ready (m_axis_tready),
        .o_pop     (q_pop),
        .o_m_valid (m_axis_tvalid),
        .o_result  (res),
        .o_out_row (res_row),
        .o_out_col (res_col),
        .o_last    (res_last)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-DATA_W-2*IDX_W){1'b0}}, res_col, res_row, res};
    assign m_axis_tlast = res_last;

endmodule

[hw/rtl/fpss_front.sv]
// ============================================================================
// fpss_front
// Raster position tracking and item classification.
// ============================================================================
module fpss_front #(
    parameter int unsigned MAX_DIM = fpss_pkg::MAX_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(MAX_DIM+1)-1:0]  i_eff_size,
    input  logic                          i_accept,
    input  logic                          i_grid_start,
    output logic [$clog2(MAX_DIM)-1:0]    o_col,
    output fpss_pkg::t_tag                o_tag
);
    import fpss_pkg::*;

    localparam int unsigned CW = $clog2(MAX_DIM);
    localparam int unsigned NW = $clog2(MAX_DIM+1);

    logic [CW-1:0]       r_row, r_col;
    logic [CW-1:0]       n_row, n_col;
    logic [CW-1:0]       cur_row, cur_col, row_m1, col_m1;
    logic [NW-1:0]       size_m1, row_inc, col_inc;
    logic [CW+IDX_W-1:0] row_ext, col_ext;
    logic                restart;

    // out-of-range position (grid shrunk) restarts like an explicit start
    assign restart = i_grid_start | (NW'(r_row) >= i_eff_size) | (NW'(r_col) >= i_eff_size);
    assign cur_row = restart ? '0 : r_row;
    assign cur_col = restart ? '0 : r_col;

    assign size_m1 = i_eff_size - 1'b1;
    assign row_inc = NW'(cur_row) + 1'b1;
    assign col_inc = NW'(cur_col) + 1'b1;

    always_comb begin
        n_row = cur_row;
        n_col = CW'(col_inc);
        if (col_inc >= i_eff_size) begin
            n_col = '0;
            n_row = (row_inc >= i_eff_size) ? '0 : CW'(row_inc);
        end
    end

    // centre of the window sits one row up, one column left
    assign row_m1  = cur_row - 1'b1;
    assign col_m1  = cur_col - 1'b1;
    assign row_ext = (CW+IDX_W)'(row_m1);
    assign col_ext = (CW+IDX_W)'(col_m1);

    assign o_col            = cur_col;
    assign o_tag.out_row    = row_ext[IDX_W-1:0];
    assign o_tag.out_col    = col_ext[IDX_W-1:0];
    assign o_tag.interior   = (NW'(cur_row) >= NW'(2)) && (NW'(cur_col) >= NW'(2));
    assign o_tag.last       = (NW'(cur_row) == size_m1) && (NW'(cur_col) == size_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

[hw/rtl/fpss_queue.sv]
// ============================================================================
// fpss_queue
// Short item queue between front and back.
// ============================================================================
module fpss_queue #(
    parameter int unsigned W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic         i_pop,
    input  logic [W-1:0] i_data,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);
    import fpss_pkg::*;

    localparam int unsigned PW   = $clog2(Q_DEPTH);
    localparam int unsigned CNTW = $clog2(Q_DEPTH+1);

    logic [W-1:0]    r_slot [Q_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CNTW-1:0] r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == CNTW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_slot[r_rp];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(Q_DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(Q_DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/fpss_back.sv]
// ============================================================================
// fpss_back
// Line stores, stencil window, scaling pipeline and output register.
// ============================================================================
module fpss_back #(
    parameter int unsigned MAX_DIM = fpss_pkg::MAX_DIM_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  logic [fpss_pkg::DATA_W-1:0]       i_sample,
    input  logic [$clog2(MAX_DIM)-1:0]        i_col,
    input  fpss_pkg::t_tag                    i_tag,
    input  logic [fpss_pkg::DATA_W-1:0]       i_fac_mag,
    input  logic                              i_fac_neg,
    input  logic                              i_m_ready,
    output logic                              o_pop,
    output logic                              o_m_valid,
    output logic [fpss_pkg::DATA_W-1:0]       o_result,
    output logic [fpss_pkg::IDX_W-1:0]        o_out_row,
    output logic [fpss_pkg::IDX_W-1:0]        o_out_col,
    output logic                              o_last
);
    import fpss_pkg::*;

    localparam int unsigned CW = $clog2(MAX_DIM);

    logic en;

    // line store (rows r-2 and r-1 packed per column)
    t_line r_mem [MAX_DIM];
    t_line r_rd, r_fwd_data, line, wr_line;
    logic  r_fwd;

    // stage 1: item with its line-store data
    logic              r_s1_v;
    logic [CW-1:0]     r_s1_col;
    logic [DATA_W-1:0] r_s1_sample;
    t_tag              r_s1_tag;

    // window: only the taps the five-point stencil reads
    logic [DATA_W-1:0] r_w_above1, r_w_mid1, r_w_mid2, r_w_samp1;

    logic              r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_s6_v;
    t_tag              r_s2_tag, r_s3_tag, r_s4_tag, r_s5_tag, r_s6_tag;
    logic [PAIR_W-1:0] r_s2_a, r_s2_b;
    logic [DATA_W-1:0] r_s2_c;
    logic [SUM_W-1:0]  r_s3_sum;
    logic [SUM_W-1:0]  r_s4_mag;
    logic              r_s4_neg, r_s5_neg, r_s6_neg;
    logic [PHI_W-1:0]  r_s5_phi;
    logic [DATA_W-1:0] r_s5_plo;
    logic [Q_W-1:0]    r_s6_q;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_result;
    t_tag              r_out_tag;

    logic [PAIR_W-1:0] pair_a, pair_b;
    logic [SUM_W-1:0]  sum, mag;
    logic [PHI_W-1:0]  p_hi;
    logic [PLO_W-1:0]  p_lo;
    logic [Q_W-1:0]    q;
    logic              over;
    logic [DATA_W-1:0] sat;

    // whole back pipeline moves together; output register frees it
    assign en    = ~r_out_valid | i_m_ready;
    assign o_pop = en & i_q_valid;

    // back-to-back items on one column: take the entry just written
    assign line          = r_fwd ? r_fwd_data : r_rd;
    assign wr_line.above  = line.middle;
    assign wr_line.middle = r_s1_sample;

    always_ff @(posedge i_clk) begin
        if (en && r_s1_v) begin
            r_mem[r_s1_col] <= wr_line;
        end
        if (en) begin
            r_rd <= r_mem[i_col];
        end
    end

    // up + down, left + right
    assign pair_a = {r_w_above1[DATA_W-1], r_w_above1} + {r_w_samp1[DATA_W-1], r_w_samp1};
    assign pair_b = {r_w_mid2[DATA_W-1], r_w_mid2} + {line.middle[DATA_W-1], line.middle};

    assign sum = {{2{r_s2_a[PAIR_W-1]}}, r_s2_a} + {{2{r_s2_b[PAIR_W-1]}}, r_s2_b}
               - {r_s2_c[DATA_W-1], r_s2_c, 2'b00};

    assign mag = r_s3_sum[SUM_W-1] ? (~r_s3_sum + 1'b1) : r_s3_sum;

    // |sum| * |factor| >> 16, split at the binary point
    assign p_hi = PHI_W'(r_s4_mag[SUM_W-1:FRAC_W]) * PHI_W'(i_fac_mag);
    assign p_lo = PLO_W'(r_s4_mag[FRAC_W-1:0]) * PLO_W'(i_fac_mag);

    assign q = Q_W'(r_s5_phi) + Q_W'(r_s5_plo);

    assign over = |r_s6_q[Q_W-1:DATA_W-1];
    always_comb begin
        if (r_s6_neg) begin
            sat = over ? SAT_NEG : (~r_s6_q[DATA_W-1:0] + 1'b1);
        end else begin
            sat = over ? SAT_POS : r_s6_q[DATA_W-1:0];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fwd       <= r_s1_v && (i_col == r_s1_col);
            r_fwd_data  <= wr_line;
            r_s1_col    <= i_col;
            r_s1_sample <= i_sample;
            r_s1_tag    <= i_tag;
            if (r_s1_v) begin
                r_w_above1 <= line.above;
                r_w_mid1   <= line.middle;
                r_w_mid2   <= r_w_mid1;
                r_w_samp1  <= r_s1_sample;
            end
            r_s2_a       <= pair_a;
            r_s2_b       <= pair_b;
            r_s2_c       <= r_w_mid1;
            r_s2_tag     <= r_s1_tag;
            r_s3_sum     <= sum;
            r_s3_tag     <= r_s2_tag;
            r_s4_mag     <= mag;
            r_s4_neg     <= r_s3_sum[SUM_W-1] ^ i_fac_neg;
            r_s4_tag     <= r_s3_tag;
            r_s5_phi     <= p_hi;
            r_s5_plo     <= p_lo[PLO_W-1:FRAC_W];
            r_s5_neg     <= r_s4_neg;
            r_s5_tag     <= r_s4_tag;
            r_s6_q       <= q;
            r_s6_neg     <= r_s5_neg;
            r_s6_tag     <= r_s5_tag;
            r_out_result <= sat;
            r_out_tag    <= r_s6_tag;
        end
    end

    // valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s3_v      <= 1'b0;
            r_s4_v      <= 1'b0;
            r_s5_v      <= 1'b0;
            r_s6_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_v      <= i_q_valid;
            r_s2_v      <= r_s1_v & r_s1_tag.interior;
            r_s3_v      <= r_s2_v;
            r_s4_v      <= r_s3_v;
            r_s5_v      <= r_s4_v;
            r_s6_v      <= r_s5_v;
            r_out_valid <= r_s6_v;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_result  = r_out_result;
    assign o_out_row = r_out_tag.out_row;
    assign o_out_col = r_out_tag.out_col;
    assign o_last    = r_out_tag.last;

endmodule

[hw/rtl/fpss_port_chk.sv]
// ============================================================================
// fpss_port_chk
// Port-level checks on the result stream of the stencil sweep.
// ============================================================================
`include "five_point_stencil_sweep_defines.svh"

module fpss_port_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // stream rules
    `FPSS_ASSERT_NEXT(a_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result item dropped while stalled")
    `FPSS_ASSERT_NEXT(a_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result item changed")

    // reset empties the pipeline
    `FPSS_ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !m_axis_tvalid, "result item shown straight after reset")

    // last interior point lies on the diagonal
    `FPSS_ASSERT_SAME(a_last_diag, m_axis_tvalid && m_axis_tlast, m_axis_tdata[41:32] == m_axis_tdata[51:42], "last point not at (n-2, n-2)")

endmodule

bind five_point_stencil_sweep fpss_port_chk u_port_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

[sim/tb_five_point_stencil_sweep.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_five_point_stencil_sweep
// Streams square grids in raster order through the stencil sweep, predicts
// each interior point's scaled Laplacian, row, column and last flag, and
// checks every result item in order. Both stream sides idle at random.
// ============================================================================

typedef struct {
    logic [31:0] value;
    logic [9:0]  row;
    logic [9:0]  col;
    logic        last;
} stencil_point_t;

// grid size register value to the size actually swept
function automatic int unsigned clamp_grid(bit [10:0] v);
    if (v < fpss_pkg::MIN_DIM) return fpss_pkg::MIN_DIM;
    if (v > fpss_pkg::MAX_DIM_DEF) return fpss_pkg::MAX_DIM_DEF;
    return v;
endfunction

class stencil_scoreboard;
    bit [10:0]      grid_reg;
    bit [31:0]      scale_reg;
    bit [31:0]      row_above [fpss_pkg::MAX_DIM_DEF];
    bit [31:0]      row_middle [fpss_pkg::MAX_DIM_DEF];
    bit [31:0]      win [9];
    int unsigned    pos_row;
    int unsigned    pos_col;
    stencil_point_t pending_points [$];
    int             mismatches;

    function new();
        grid_reg   = fpss_pkg::GRID_RST;
        scale_reg  = fpss_pkg::SCALE_RST;
        pos_row    = 0;
        pos_col    = 0;
        mismatches = 0;
    endfunction

    function void write_reg(fpss_pkg::t_reg_idx idx, bit [31:0] value);
        case (idx)
            fpss_pkg::REG_GRID_SIZE:    grid_reg = value[10:0];
            fpss_pkg::REG_SCALE_FACTOR: scale_reg = value;
            default: ;
        endcase
    endfunction

    function longint widen(bit [31:0] x);
        return longint'($signed(x));
    endfunction

    // factor * sum >> 16, truncated toward zero, clipped to 32 bits signed
    function bit [31:0] scaled_laplacian(longint sum, longint factor);
        bit              neg;
        longint unsigned ms;
        longint unsigned mf;
        longint unsigned q;
        neg = (sum < 0) != (factor < 0);
        ms  = (sum < 0) ? -sum : sum;
        mf  = (factor < 0) ? -factor : factor;
        q   = (ms >> 16) * mf + (((ms & 64'hFFFF) * mf) >> 16);
        if (q == 0) return 32'h0;
        if (neg) begin
            if (q >= 64'h8000_0000) return fpss_pkg::SAT_NEG;
            return 32'(64'h1_0000_0000 - q);
        end
        if (q > 64'h7FFF_FFFF) return fpss_pkg::SAT_POS;
        return q[31:0];
    endfunction

    function void note_sample(bit [31:0] s, bit start);
        int unsigned    n;
        int unsigned    r;
        int unsigned    c;
        longint         sum;
        stencil_point_t pt;
        n = clamp_grid(grid_reg);
        r = pos_row;
        c = pos_col;
        if (start || r >= n || c >= n) begin
            r = 0;
            c = 0;
        end
        for (int k = 0; k < 3; k++) begin
            win[k*3]   = win[k*3+1];
            win[k*3+1] = win[k*3+2];
        end
        win[2] = row_above[c];
        win[5] = row_middle[c];
        win[8] = s;
        row_above[c]  = row_middle[c];
        row_middle[c] = s;
        // window centre is one row up and one column left of the sample
        if (r >= 2 && c >= 2) begin
            sum = widen(win[1]) + widen(win[7]) + widen(win[3]) + widen(win[5])
                  - 4 * widen(win[4]);
            pt.value = scaled_laplacian(sum, widen(scale_reg));
            pt.row   = 10'(r - 1);
            pt.col   = 10'(c - 1);
            pt.last  = (r == n - 1) && (c == n - 1);
            pending_points.push_back(pt);
        end
        c++;
        if (c >= n) begin
            c = 0;
            r++;
            if (r >= n) r = 0;
        end
        pos_row = r;
        pos_col = c;
    endfunction

    function int pending_count();
        return pending_points.size();
    endfunction

    task report_mismatch(string msg);
        if (mismatches < 100)
            $display("%0t MISMATCH %s", $time, msg);
        mismatches++;
    endtask

    task check_result(logic [fpss_pkg::OUT_TDATA_W-1:0] data, logic last);
        stencil_point_t want;
        if (pending_points.size() == 0) begin
            report_mismatch($sformatf("result item with none pending, tdata=%h", data));
            return;
        end
        want = pending_points.pop_front();
        if (data[31:0] !== want.value)
            report_mismatch($sformatf("(%0d,%0d) value %h, want %h",
                want.row, want.col, data[31:0], want.value));
        if (data[41:32] !== want.row)
            report_mismatch($sformatf("row %0d, want %0d", data[41:32], want.row));
        if (data[51:42] !== want.col)
            report_mismatch($sformatf("col %0d, want %0d", data[51:42], want.col));
        if (data[55:52] !== 4'h0)
            report_mismatch($sformatf("pad bits %h not zero", data[55:52]));
        if (last !== want.last)
            report_mismatch($sformatf("(%0d,%0d) tlast %b, want %b",
                want.row, want.col, last, want.last));
    endtask
endclass

module tb_five_point_stencil_sweep;
    import fpss_pkg::*;

    localparam int unsigned RANDOM_ITEMS  = 700;
    localparam int unsigned IDLE_LIMIT    = 2000;  // cycles with no item moving
    localparam int unsigned SETTLE_CYCLES = 12;    // pipeline is 7 deep

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    t_reg_idx               i_cfg_idx = REG_GRID_SIZE;
    logic [DATA_W-1:0]      i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [DATA_W-1:0]      s_axis_tdata = '0;   // [31:0] sample
    logic                   s_axis_tuser = 1'b0; // [0] grid_start
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [31:0] result, [41:32] row,
                                                 // [51:42] col, [55:52] zero
    logic                   m_axis_tlast;        // last_point

    // per-phase switches: no idling at all on that side when set
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    int idle_cycles = 0;

    stencil_scoreboard book;

    five_point_stencil_sweep uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // sample value by flavour: full random, small magnitudes, corner values
    function automatic bit [31:0] pick_sample(int mode);
        case (mode)
            1: return 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
            2: begin
                case ($urandom_range(0, 5))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'h0000_0001;
                    4: return 32'hFFFF_FFFF;
                    default: return $urandom;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic bit [31:0] pick_scale();
        case ($urandom_range(0, 5))
            0: return SCALE_RST;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h0000_0000;
            4: return 32'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    task write_register(t_reg_idx idx, bit [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        book.write_reg(idx, value);
        @(posedge i_clk);
    endtask

    // one item in: random gap, then hold until the block takes it
    task send_sample(bit [31:0] s, bit start);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        s_axis_tuser  <= start;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
        book.note_sample(s, start);
    endtask

    // a stray grid_start now and then breaks the raster on purpose
    task run_phase(int unsigned count, bit first_start, int mode);
        bit start;
        for (int unsigned i = 0; i < count; i++) begin
            start = (i == 0) ? first_start : ($urandom_range(0, 39) == 0);
            send_sample(pick_sample(mode), start);
        end
    endtask

    // stop sending, let every pending result out, then cover boundary items
    // still in flight
    task settle_idle();
        s_axis_tvalid <= 1'b0;
        while (book.pending_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // result side: random stall before each item, then take it
    initial begin : result_sink
        int stall;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (m_axis_tvalid !== 1'b1) @(posedge i_clk);
            book.check_result(m_axis_tdata, m_axis_tlast);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_five_point_stencil_sweep: errors");
            $finish;
        end
    end

    initial begin : stimulus
        bit [31:0]   spike [9];
        bit [10:0]   grid_val;
        int unsigned cur_eff;
        int unsigned next_eff;
        int unsigned count;
        int unsigned sent_random;
        bit          first_start;

        book = new();
        // centre at the top of the range, the four neighbours at the bottom
        spike = '{32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // grid size 0 acts as 3; sum far negative, largest scale: clips low
        write_register(REG_GRID_SIZE, 32'd0);
        write_register(REG_SCALE_FACTOR, 32'h7FFF_FFFF);
        for (int k = 0; k < 9; k++) send_sample(spike[k], k == 0);

        // grid of 4 left at row 1, column 3
        settle_idle();
        write_register(REG_GRID_SIZE, 32'd4);
        for (int k = 0; k < 7; k++) send_sample(pick_sample(2), k == 0);

        // shrink to 3 (written as 1): column 3 lies past the grid, so the
        // next item restarts without grid_start; negative scale clips high
        settle_idle();
        write_register(REG_GRID_SIZE, 32'd1);
        write_register(REG_SCALE_FACTOR, 32'h8000_0000);
        for (int k = 0; k < 9; k++) send_sample(spike[k], 1'b0);
        cur_eff = 3;

        // grid size above the maximum: one full row of 1024 and a few more,
        // leaving row 1, column 6, where a smaller next grid may carry on
        settle_idle();
        write_register(REG_GRID_SIZE, 32'h7FF);
        write_register(REG_SCALE_FACTOR, pick_scale());
        tx_burst = ($urandom_range(0, 1) == 0);
        rx_burst = 1'b0;
        run_phase(MAX_DIM_DEF + 6, 1'b1, 0);
        cur_eff = MAX_DIM_DEF;

        // random phases of small grids; a raised size always opens with
        // grid_start so no line store entry is read before it is written
        sent_random = 0;
        while (sent_random < RANDOM_ITEMS) begin
            settle_idle();
            case ($urandom_range(0, 7))
                0:       grid_val = 11'($urandom_range(0, 2));
                1:       grid_val = 11'($urandom_range(11, 24));
                default: grid_val = 11'($urandom_range(3, 10));
            endcase
            next_eff    = clamp_grid(grid_val);
            first_start = (next_eff > cur_eff) ? 1'b1 : 1'($urandom_range(0, 1));
            if ($urandom_range(0, 2) != 0)
                write_register(REG_SCALE_FACTOR, pick_scale());
            write_register(REG_GRID_SIZE, 32'(grid_val));
            cur_eff = next_eff;
            count = next_eff * next_eff * $urandom_range(1, 3);
            if (count > 300) count = 300;
            count += $urandom_range(0, next_eff - 1);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            run_phase(count, first_start, $urandom_range(0, 2));
            sent_random += count;
        end

        settle_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (book.mismatches == 0 && book.pending_count() == 0)
            $display("tb_five_point_stencil_sweep: clean");
        else
            $display("tb_five_point_stencil_sweep: errors");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/fpss_pkg.sv
hw/rtl/fpss_front.sv
hw/rtl/fpss_queue.sv
hw/rtl/fpss_back.sv
hw/rtl/five_point_stencil_sweep.sv
hw/rtl/fpss_port_chk.sv
sim/tb_five_point_stencil_sweep.sv
